// File: hdl/rcdc_pkg.sv
// rcdc_pkg: shared types, constants and table builders for the rabin chunker
// beat structs, register indexes, window control struct, polynomial rom functions
// no dependencies
package rcdc_pkg;

	localparam int unsigned DIGEST_W = 53;
	localparam logic [63:0] POLY = 64'h003D_A335_8B4D_C173;

	localparam logic [15:0] MIN_CHUNK_RST = 16'd4096;
	localparam logic [15:0] MAX_CHUNK_RST = 16'd16384;
	localparam logic [4:0]  AVG_BITS_RST  = 5'd13;

	typedef logic [DIGEST_W-1:0] digest_t;
	typedef digest_t tab_t [256];

	typedef enum logic [1:0] {
		CFG_MIN_CHUNK = 2'd0,
		CFG_MAX_CHUNK = 2'd1,
		CFG_AVG_BITS  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} in_beat_t;

	typedef struct packed {
		logic        boundary;
		logic        final_chunk;
		logic [31:0] chunk_offset;
		logic [15:0] chunk_length;
		digest_t     fingerprint;
	} out_beat_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic restart;
	} win_ctl_t;

	// remainder modulo the polynomial
	function automatic logic [63:0] poly_mod(input logic [63:0] x);
		logic [63:0] r;
		r = x;
		for (int bit_i = 63; bit_i >= int'(DIGEST_W); bit_i--) begin
			if (r[bit_i]) begin
				r = r ^ (POLY << (bit_i - int'(DIGEST_W)));
			end
		end
		return r;
	endfunction

	function automatic tab_t build_reduce();
		tab_t t;
		logic [63:0] top;
		for (int b = 0; b < 256; b++) begin
			top = 64'(b) << DIGEST_W;
			t[b] = DIGEST_W'(poly_mod(top));
		end
		return t;
	endfunction

	// contribution of a byte after it has moved through the whole window
	function automatic tab_t build_leave(input int unsigned nbytes);
		tab_t t;
		logic [63:0] h;
		for (int b = 0; b < 256; b++) begin
			h = 64'(b);
			for (int unsigned i = 0; i + 1 < nbytes; i++) begin
				h = poly_mod(h << 8);
			end
			t[b] = DIGEST_W'(h);
		end
		return t;
	endfunction

	localparam tab_t REDUCE_TAB = build_reduce();

endpackage

// File: hdl/rcdc_ram.sv
// rcdc_ram: generic single write port, single read port ram
// registered read data, read data holds while read enable is low; no dependencies
module rcdc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/rcdc_window.sv
// rcdc_window: byte window store with per-entry valid bits cleared at restart
// instantiates rcdc_ram; uses rcdc_pkg for the control struct
module rcdc_window #(
	parameter int unsigned WINDOW_BYTES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rcdc_pkg::win_ctl_t              ctl,
	input  logic [$clog2(WINDOW_BYTES)-1:0] rd_addr,
	input  logic [$clog2(WINDOW_BYTES)-1:0] wr_addr,
	input  logic [7:0]                      wr_data,
	output logic [7:0]                      gone
);
	import rcdc_pkg::*;

	localparam int unsigned SLOT_W = $clog2(WINDOW_BYTES);

	logic [WINDOW_BYTES-1:0] valid_q;
	logic [7:0]              rdata;

	rcdc_ram #(
		.WIDTH(8),
		.DEPTH(WINDOW_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (ctl.wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (ctl.rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.restart) begin
			valid_q <= '0;
		end else if (ctl.wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// an unwritten entry holds the seed: one at entry zero, zero elsewhere
	always_comb begin
		if (valid_q[wr_addr]) begin
			gone = rdata;
		end else if (wr_addr == SLOT_W'(0)) begin
			gone = 8'd1;
		end else begin
			gone = 8'd0;
		end
	end

endmodule

// File: hdl/rabin_content_defined_chunker_core.sv
// rabin_content_defined_chunker_core: rolling rabin digest and chunk cut logic
// uses rcdc_pkg, rcdc_window (which holds rcdc_ram)
//
//  channel | dir | handshake          | beat
//  in      | in  | in_valid/in_stall  | rcdc_pkg::in_beat_t
//  out     | out | out_valid/out_stall| rcdc_pkg::out_beat_t
//  cfg     | in  | cfg_we             | cfg_index, cfg_data
//
// one byte per cycle sustained while the output is not stalled
// the window ram read for a byte is issued at acceptance, the digest update and
// cut decision are made in the first stage, then the output register
// after reset the block takes beats at once; window restart clears all valid bits at once
// an output stall on a waiting result holds the first stage and stalls the input
// in the same cycle when that stage is full
module rabin_content_defined_chunker_core #(
	parameter int unsigned WINDOW_BYTES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rcdc_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output rcdc_pkg::out_beat_t out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import rcdc_pkg::*;

	localparam int unsigned SLOT_W = $clog2(WINDOW_BYTES);
	localparam tab_t LEAVE_TAB = build_leave(WINDOW_BYTES);

	logic [15:0] min_q;
	logic [15:0] max_q;
	logic [4:0]  avg_q;

	logic              s1_valid_s1;
	logic [7:0]        byte_s1;
	logic              eos_s1;

	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] slot_inc;
	digest_t           digest_q;
	logic [15:0]       count_q;
	logic [31:0]       offset_q;
	logic [31:0]       start_q;

	logic              out_valid_q;
	out_beat_t         out_q;

	logic              accept;
	logic              adv;
	win_ctl_t          win_ctl;
	logic [SLOT_W-1:0] rd_addr;
	logic [7:0]        gone;

	digest_t           d_left;
	digest_t           d_new;
	digest_t           avg_mask;
	logic [7:0]        top_idx;
	logic [15:0]       count_new;
	logic [31:0]       offset_new;
	logic              cut;
	logic              fire;
	out_beat_t         res;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_CHUNK_RST;
			max_q <= MAX_CHUNK_RST;
			avg_q <= AVG_BITS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MIN_CHUNK: min_q <= cfg_data;
				CFG_MAX_CHUNK: max_q <= cfg_data;
				CFG_AVG_BITS:  avg_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign adv       = s1_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = s1_valid_s1 && !adv;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		if (slot_q == SLOT_W'(WINDOW_BYTES - 1)) begin
			slot_inc = '0;
		end else begin
			slot_inc = slot_q + 1'b1;
		end
	end

	// the next slot is slot_q + 1, wrapping to zero, unless the byte in flight cuts; after a cut
	// the slot read is invalid anyway, so the prefetched data is ignored
	assign rd_addr = s1_valid_s1 ? slot_inc : slot_q;

	always_comb begin
		win_ctl.rd_en   = accept;
		win_ctl.wr_en   = adv;
		win_ctl.restart = adv && fire;
	end

	rcdc_window #(
		.WINDOW_BYTES(WINDOW_BYTES)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (win_ctl),
		.rd_addr(rd_addr),
		.wr_addr(slot_q),
		.wr_data(byte_s1),
		.gone   (gone)
	);

	// digest roll and cut decision
	always_comb begin
		for (int i = 0; i < int'(DIGEST_W); i++) begin
			avg_mask[i] = (6'(i) < {1'b0, avg_q});
		end
		d_left     = digest_q ^ LEAVE_TAB[gone];
		top_idx    = d_left[DIGEST_W-1 -: 8];
		d_new      = {d_left[DIGEST_W-9:0], byte_s1} ^ REDUCE_TAB[top_idx];
		count_new  = count_q + 16'd1;
		offset_new = offset_q + 32'd1;
		cut        = ((count_new >= min_q) && ((d_new & avg_mask) == '0)) ||
			(count_new >= max_q);
		fire       = cut || eos_s1;
		res              = '0;
		res.boundary     = fire;
		res.final_chunk  = fire && eos_s1;
		if (fire) begin
			res.chunk_offset = start_q;
			res.chunk_length = count_new;
			res.fingerprint  = d_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= 1'b1;
		end else if (adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_data.data_byte;
			eos_s1  <= in_data.end_of_stream;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= SLOT_W'(1);
			digest_q <= DIGEST_W'(1);
			count_q  <= '0;
			offset_q <= '0;
			start_q  <= '0;
		end else if (adv) begin
			if (fire) begin
				slot_q   <= SLOT_W'(1);
				digest_q <= DIGEST_W'(1);
				count_q  <= '0;
				offset_q <= eos_s1 ? 32'd0 : offset_new;
				start_q  <= eos_s1 ? 32'd0 : offset_new;
			end else begin
				slot_q   <= slot_inc;
				digest_q <= d_new;
				count_q  <= count_new;
				offset_q <= offset_new;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

endmodule

// File: tb/rabin_content_defined_chunker_core_tb.sv
// testbench for rabin_content_defined_chunker_core: directed table then random byte streams,
// every result beat checked against its directed table entry or an in-bench rolling rabin predictor
// depends on rcdc_pkg and the core rtl only
`timescale 1ns / 1ps

module rabin_content_defined_chunker_core_tb;
	import rcdc_pkg::*;

	localparam int unsigned WIN = 64;
	localparam logic [53:0] RABIN_POLY = 54'h3D_A335_8B4D_C173;
	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam int unsigned PHASE_BEATS = 125;
	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic        is_cfg;
		logic [1:0]  reg_idx;
		logic [15:0] reg_val;
		logic        typed;
		in_beat_t    beat;
		out_beat_t   want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_beat_t in_data;
	logic out_valid;
	logic out_stall;
	out_beat_t out_data;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	// predictor state
	digest_t fold_rom [256];
	digest_t drop_rom [256];
	logic [7:0] win_mem [WIN];
	logic [5:0] win_slot;
	digest_t roll_fp;
	logic [15:0] run_len;
	logic [31:0] strm_pos;
	logic [31:0] chunk_base;
	logic [15:0] cut_min;
	logic [15:0] cut_max;
	logic [4:0] zero_bits;

	out_beat_t pending_chunks [$];
	plan_row_t plan [25];

	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned cycles;
	int unsigned mismatches;
	int unsigned bytes_sent;
	int unsigned chunk_ends;
	int unsigned flushes;
	int unsigned reg_writes;

	rabin_content_defined_chunker_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// v * x^n modulo the polynomial, one bit at a time
	function automatic digest_t mul_xpow(input digest_t v, input int n);
		digest_t r;
		logic carry;
		r = v;
		for (int i = 0; i < n; i++) begin
			carry = r[52];
			r = {r[51:0], 1'b0};
			if (carry) begin
				r = r ^ RABIN_POLY[52:0];
			end
		end
		return r;
	endfunction

	task automatic shift_in(input logic [7:0] b);
		logic [7:0] gone;
		logic [7:0] top;
		gone = win_mem[win_slot];
		win_mem[win_slot] = b;
		roll_fp = roll_fp ^ drop_rom[gone];
		win_slot = win_slot + 6'd1;
		top = roll_fp[52:45];
		roll_fp = {roll_fp[44:0], b} ^ fold_rom[top];
	endtask

	task automatic restart_fp();
		for (int i = 0; i < WIN; i++) begin
			win_mem[i] = 8'h00;
		end
		win_slot = 6'd0;
		roll_fp = '0;
		run_len = 16'd0;
		shift_in(8'h01);
	endtask

	task automatic predict_chunk(input in_beat_t beat, output out_beat_t res);
		digest_t low_mask;
		logic cut;
		shift_in(beat.data_byte);
		run_len = run_len + 16'd1;
		strm_pos = strm_pos + 32'd1;
		low_mask = (digest_t'(1) << zero_bits) - digest_t'(1);
		cut = (run_len >= cut_min && (roll_fp & low_mask) == '0) || run_len >= cut_max;
		res = '0;
		if (cut || beat.end_of_stream) begin
			res.boundary = 1'b1;
			res.final_chunk = beat.end_of_stream;
			res.chunk_offset = chunk_base;
			res.chunk_length = run_len;
			res.fingerprint = roll_fp;
			restart_fp();
			if (beat.end_of_stream) begin
				strm_pos = 32'd0;
				chunk_base = 32'd0;
			end else begin
				chunk_base = strm_pos;
			end
		end
	endtask

	function automatic plan_row_t reg_row(input logic [1:0] idx, input logic [15:0] val);
		plan_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	function automatic plan_row_t byte_row(input logic [7:0] d, input logic eos);
		plan_row_t r;
		r = '0;
		r.beat.data_byte = d;
		r.beat.end_of_stream = eos;
		return r;
	endfunction

	function automatic plan_row_t known_row(input logic [7:0] d, input logic eos,
		input out_beat_t w);
		plan_row_t r;
		r = byte_row(d, eos);
		r.typed = 1'b1;
		r.want = w;
		return r;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_MIN_CHUNK: cut_min = val;
			CFG_MAX_CHUNK: cut_max = val;
			CFG_AVG_BITS:  zero_bits = val[4:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// hold off the sender until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_chunks.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic send_byte(input in_beat_t beat, input logic typed, input out_beat_t want);
		out_beat_t guess;
		in_valid <= 1'b1;
		in_data <= beat;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		predict_chunk(beat, guess);
		pending_chunks.push_back(typed ? want : guess);
		bytes_sent++;
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(0, 99) < tx_idle_pct);
		end
	endtask

	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("rabin_content_defined_chunker_core_tb: done, errors");
			$finish;
		end else begin
			cycles <= cycles + 1;
		end
	end

	always @(posedge clk) begin : rx
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (out_data.boundary) chunk_ends++;
			if (out_data.final_chunk) flushes++;
			if (pending_chunks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result beat: b=%0b f=%0b off=%0h len=%0d fp=%0h",
						out_data.boundary, out_data.final_chunk, out_data.chunk_offset,
						out_data.chunk_length, out_data.fingerprint);
				end
			end else begin
				want = pending_chunks.pop_front();
				if (out_data.boundary !== want.boundary
					|| out_data.final_chunk !== want.final_chunk
					|| out_data.chunk_offset !== want.chunk_offset
					|| out_data.chunk_length !== want.chunk_length
					|| out_data.fingerprint !== want.fingerprint) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected b=%0b f=%0b off=%0h len=%0d fp=%0h",
							want.boundary, want.final_chunk, want.chunk_offset,
							want.chunk_length, want.fingerprint);
						$display("          actual   b=%0b f=%0b off=%0h len=%0d fp=%0h",
							out_data.boundary, out_data.final_chunk, out_data.chunk_offset,
							out_data.chunk_length, out_data.fingerprint);
					end
				end
			end
		end
		out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
	end

	initial begin
		in_beat_t beat;
		logic [15:0] lo;
		logic [15:0] hi;
		logic [4:0] bits;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MIN_CHUNK;
		cfg_data = 16'd0;
		cycles = 0;
		mismatches = 0;
		bytes_sent = 0;
		chunk_ends = 0;
		flushes = 0;
		reg_writes = 0;
		tx_idle_pct = 16;
		rx_idle_pct = 70;

		for (int b = 0; b < 256; b++) begin
			fold_rom[b] = mul_xpow(digest_t'(b), 53);
			drop_rom[b] = mul_xpow(digest_t'(b), 8 * (WIN - 1));
		end
		cut_min = MIN_CHUNK_RST;
		cut_max = MAX_CHUNK_RST;
		zero_bits = AVG_BITS_RST;
		restart_fp();
		strm_pos = 32'd0;
		chunk_base = 32'd0;

		plan = '{
			known_row(8'hFF, 1'b0, '0),
			byte_row(8'h00, 1'b1),
			known_row(8'hFF, 1'b1, {1'b1, 1'b1, 32'd0, 16'd1, 53'h1FF}),
			known_row(8'h00, 1'b1, {1'b1, 1'b1, 32'd0, 16'd1, 53'h100}),
			reg_row(CFG_MAX_CHUNK, 16'd0),
			known_row(8'hA5, 1'b0, {1'b1, 1'b0, 32'd0, 16'd1, 53'h1A5}),
			known_row(8'h5A, 1'b0, {1'b1, 1'b0, 32'd1, 16'd1, 53'h15A}),
			known_row(8'h3C, 1'b1, {1'b1, 1'b1, 32'd2, 16'd1, 53'h13C}),
			reg_row(CFG_MIN_CHUNK, 16'hFFFF),
			reg_row(CFG_MAX_CHUNK, 16'd3),
			byte_row(8'h12, 1'b0),
			byte_row(8'h80, 1'b0),
			byte_row(8'h7F, 1'b0),
			reg_row(CFG_AVG_BITS, 16'd0),
			reg_row(CFG_MIN_CHUNK, 16'd2),
			reg_row(CFG_MAX_CHUNK, 16'hFFFF),
			byte_row(8'h01, 1'b0),
			byte_row(8'hFE, 1'b0),
			byte_row(8'h40, 1'b0),
			byte_row(8'hBF, 1'b0),
			reg_row(CFG_AVG_BITS, 16'd31),
			reg_row(CFG_MIN_CHUNK, 16'd1),
			byte_row(8'h55, 1'b0),
			byte_row(8'hAA, 1'b0),
			byte_row(8'h00, 1'b1)
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_byte(plan[i].beat, plan[i].typed, plan[i].want);
			end
		end

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			tx_idle_pct = (ph < 3) ? 16 : (ph < 6) ? 70 : 0;
			rx_idle_pct = (ph < 3) ? 70 : (ph < 6) ? 16 : 0;
			case (ph)
				0: begin lo = 16'd8; hi = 16'd64; bits = 5'd3; end
				1: begin lo = 16'd0; hi = 16'd40; bits = 5'd1; end
				2: begin lo = 16'd16; hi = 16'd128; bits = 5'd5; end
				3: begin lo = 16'hFFFF; hi = 16'hFFFF; bits = 5'd31; end
				4: begin
					lo = 16'($urandom_range(1, 32));
					hi = 16'($urandom_range(33, 256));
					bits = 5'($urandom_range(1, 6));
				end
				5: begin lo = 16'd1; hi = 16'd1; bits = 5'd0; end
				6: begin lo = 16'd100; hi = 16'd20; bits = 5'd4; end
				default: begin
					lo = 16'($urandom_range(0, 64));
					hi = 16'($urandom_range(1, 200));
					bits = 5'($urandom_range(0, 8));
				end
			endcase
			write_reg(CFG_MIN_CHUNK, lo);
			write_reg(CFG_MAX_CHUNK, hi);
			// upper data bits are don't-care for the 5-bit register
			write_reg(CFG_AVG_BITS, {11'($urandom), bits});
			if (ph == 4) begin
				write_reg(CFG_SPARE, 16'($urandom));
			end
			for (int k = 0; k < PHASE_BEATS; k++) begin
				if (ph == 1 && k == PHASE_BEATS / 2) begin
					drain();
				end
				if ($urandom_range(0, 3) == 0) begin
					case ($urandom_range(0, 2))
						0: beat.data_byte = 8'h00;
						1: beat.data_byte = 8'hFF;
						default: beat.data_byte = 8'($urandom_range(0, 3));
					endcase
				end else begin
					beat.data_byte = 8'($urandom_range(0, 255));
				end
				beat.end_of_stream = ($urandom_range(0, 79) == 0);
				send_byte(beat, 1'b0, '0);
			end
		end

		drain();
		repeat (16) @(posedge clk);
		$display("streamed %0d bytes through %0d register writes", bytes_sent, reg_writes);
		$display("saw %0d chunk ends, %0d of them end-of-stream flushes, %0d mismatches",
			chunk_ends, flushes, mismatches);
		if (mismatches == 0 && pending_chunks.size() == 0) begin
			$display("rabin_content_defined_chunker_core_tb: done, clean");
		end else begin
			$display("rabin_content_defined_chunker_core_tb: done, errors");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/rcdc_pkg.sv
hdl/rcdc_ram.sv
hdl/rcdc_window.sv
hdl/rabin_content_defined_chunker_core.sv
tb/rabin_content_defined_chunker_core_tb.sv
